// File: sv/eug_pkg.sv
// Shared types and constants for the energy utterance gate.
// No dependencies; imported by every module of the block.
package eug_pkg;

    localparam int MaxFrameSamples = 4096;
    localparam int SampleW = 16;
    localparam int MagW    = SampleW + 1;
    localparam int SqW     = 2 * SampleW - 1;
    localparam int CntW    = $clog2(MaxFrameSamples + 1);
    localparam int SumW    = SqW + CntW - 1;
    localparam int ThrW    = 31;
    localparam int LimW    = 24;
    localparam int ProdW   = ThrW + CntW;
    localparam int CfgIdxW = 2;
    localparam int CfgW    = ThrW;

    localparam logic [ThrW-1:0] ThrReset = ThrW'(1074);
    localparam logic [LimW-1:0] SilReset = LimW'(12000);
    localparam logic [LimW-1:0] UttReset = LimW'(288000);

    localparam logic CmdSample = 1'b0;
    localparam logic CmdClear  = 1'b1;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_SIL_LIMIT = 2'd1,
        CFG_UTT_LIMIT = 2'd2
    } t_cfg_idx;

    // one beat per frame end or clear command
    typedef struct packed {
        logic             clear;
        logic [SumW-1:0]  sum;
        logic [CntW-1:0]  n;
    } t_frame_beat;

endpackage

// File: sv/eug_frame_acc.sv
// Sample front end: input register, squaring, per-frame energy accumulation.
// Depends on eug_pkg; emits one t_frame_beat per frame end or clear.
module eug_frame_acc import eug_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_cmd,
    input  logic signed [SampleW-1:0] i_sample,
    input  logic               i_frame_last,
    output logic               o_beat_valid,
    input  logic               i_beat_ready,
    output t_frame_beat        o_beat
);

    logic               r_s1_v;
    logic               r_s1_cmd;
    logic [SampleW-1:0] r_s1_sample;
    logic               r_s1_last;

    logic               r_s2_v;
    logic               r_s2_cmd;
    logic [SqW-1:0]     r_s2_sq;
    logic               r_s2_last;

    logic               r_b_v;
    t_frame_beat        r_beat;

    logic [SumW-1:0]    r_energy_sum;
    logic [CntW-1:0]    r_frame_count;

    logic               s1_ready, s2_ready, b_ready;
    logic               s1_fire, s2_fire;
    logic [MagW-1:0]    mag;
    logic [2*MagW-1:0]  sq_full;
    logic [SumW-1:0]    n_energy_sum;
    logic [CntW-1:0]    n_frame_count;
    logic               frame_end;
    logic               s2_emits;

    assign b_ready  = !r_b_v || i_beat_ready;
    assign s2_ready = !r_s2_v || b_ready;
    assign s1_ready = !r_s1_v || s2_ready;
    assign o_ready  = s1_ready;
    assign s1_fire  = r_s1_v && s2_ready;
    assign s2_fire  = r_s2_v && b_ready;

    always_comb begin
        if (r_s1_sample[SampleW-1]) begin
            mag = MagW'(1 << SampleW) - {1'b0, r_s1_sample};
        end else begin
            mag = {1'b0, r_s1_sample};
        end
        sq_full = mag * mag;
    end

    assign n_energy_sum  = r_energy_sum + SumW'(r_s2_sq);
    assign n_frame_count = r_frame_count + 1'b1;
    assign frame_end     = r_s2_last || (n_frame_count == CntW'(MaxFrameSamples));
    assign s2_emits      = (r_s2_cmd == CmdClear) || frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v        <= 1'b0;
            r_s2_v        <= 1'b0;
            r_b_v         <= 1'b0;
            r_energy_sum  <= '0;
            r_frame_count <= '0;
        end else begin
            if (s1_ready) begin
                r_s1_v <= i_valid;
            end
            if (s2_ready) begin
                r_s2_v <= s1_fire;
            end
            if (b_ready) begin
                r_b_v <= s2_fire && s2_emits;
            end
            if (s2_fire) begin
                if (s2_emits) begin
                    r_energy_sum  <= '0;
                    r_frame_count <= '0;
                end else begin
                    r_energy_sum  <= n_energy_sum;
                    r_frame_count <= n_frame_count;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && s1_ready) begin
            r_s1_cmd    <= i_cmd;
            r_s1_sample <= i_sample;
            r_s1_last   <= i_frame_last;
        end
        if (s1_fire) begin
            r_s2_cmd  <= r_s1_cmd;
            r_s2_sq   <= sq_full[SqW-1:0];
            r_s2_last <= r_s1_last;
        end
        if (s2_fire && s2_emits) begin
            r_beat.clear <= (r_s2_cmd == CmdClear);
            r_beat.sum   <= n_energy_sum;
            r_beat.n     <= n_frame_count;
        end
    end

    assign o_beat_valid = r_b_v;
    assign o_beat       = r_beat;

endmodule

// File: sv/eug_gate.sv
// Frame decision and utterance gate: threshold product, compare, counters.
// Depends on eug_pkg; consumes t_frame_beat from eug_frame_acc.
module eug_gate import eug_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_beat_valid,
    output logic            o_beat_ready,
    input  t_frame_beat     i_beat,
    input  logic [ThrW-1:0] i_threshold,
    input  logic [LimW-1:0] i_sil_limit,
    input  logic [LimW-1:0] i_utt_limit,
    output logic            o_valid,
    input  logic            i_ready,
    output logic            o_keep,
    output logic            o_complete,
    output logic            o_started
);

    logic              r_m_v;
    logic              r_m_clear;
    logic [SumW-1:0]   r_m_sum;
    logic [ProdW-1:0]  r_m_prod;
    logic [CntW-1:0]   r_m_n;

    logic              r_speech_heard;
    logic [LimW-1:0]   r_utt_count;
    logic [LimW-1:0]   r_sil_count;

    logic              r_out_v;
    logic              r_keep, r_complete, r_started;

    logic              out_ready, m_ready, m_fire;
    logic              speech, gated;
    logic [LimW:0]     utt_sum, sil_sum;
    logic [LimW-1:0]   n_utt_count, n_sil_count;

    assign out_ready    = !r_out_v || i_ready;
    assign m_ready      = !r_m_v || out_ready;
    assign o_beat_ready = m_ready;
    assign m_fire       = r_m_v && out_ready;

    always_comb begin
        speech  = {{(ProdW-SumW){1'b0}}, r_m_sum} >= r_m_prod;
        gated   = !speech && !r_speech_heard;
        utt_sum = {1'b0, r_utt_count} + (LimW+1)'(r_m_n);
        sil_sum = {1'b0, r_sil_count} + (LimW+1)'(r_m_n);
        n_utt_count = utt_sum[LimW] ? '1 : utt_sum[LimW-1:0];
        if (speech) begin
            n_sil_count = '0;
        end else begin
            n_sil_count = sil_sum[LimW] ? '1 : sil_sum[LimW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v          <= 1'b0;
            r_out_v        <= 1'b0;
            r_speech_heard <= 1'b0;
            r_utt_count    <= '0;
            r_sil_count    <= '0;
        end else begin
            if (m_ready) begin
                r_m_v <= i_beat_valid;
            end
            if (out_ready) begin
                r_out_v <= m_fire && !r_m_clear;
            end
            if (m_fire) begin
                if (r_m_clear) begin
                    r_speech_heard <= 1'b0;
                    r_utt_count    <= '0;
                    r_sil_count    <= '0;
                end else if (!gated) begin
                    r_speech_heard <= 1'b1;
                    r_utt_count    <= n_utt_count;
                    r_sil_count    <= n_sil_count;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_beat_valid && m_ready) begin
            r_m_clear <= i_beat.clear;
            r_m_sum   <= i_beat.sum;
            r_m_prod  <= i_threshold * i_beat.n;
            r_m_n     <= i_beat.n;
        end
        if (m_fire && !r_m_clear) begin
            r_keep     <= !gated;
            r_complete <= !gated && ((n_sil_count >= i_sil_limit) ||
                                     (n_utt_count >= i_utt_limit));
            r_started  <= speech && !r_speech_heard;
        end
    end

    assign o_valid    = r_out_v;
    assign o_keep     = r_keep;
    assign o_complete = r_complete;
    assign o_started  = r_started;

endmodule

// File: sv/energy_utterance_gate.sv
// Top level of the energy utterance gate: configuration registers and wiring.
// Depends on eug_pkg, eug_frame_acc and eug_gate.
//
// Accepts one beat (audio sample or clear command) per clock cycle with no
// gaps; the per-sample square, the energy accumulator add and the frame
// decision form a five-stage pipeline with one accumulate per cycle, so
// throughput is one beat per cycle while i_ready stays high. A frame result
// passes the input, square, beat, product and output registers after the
// beat ending the frame (frame_last set, or the frame reaching 4096 samples);
// other beats give no result. Frame energy is compared against threshold
// times sample count, so no root is taken. Registers: 0 threshold, 1 silence
// limit, 2 utterance limit; write them only with the pipeline drained.
module energy_utterance_gate import eug_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_cmd,
    input  logic signed [SampleW-1:0] i_sample,
    input  logic                      i_frame_last,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_keep,
    output logic                      o_complete,
    output logic                      o_started,
    input  logic                      i_cfg_we,
    input  logic [CfgIdxW-1:0]        i_cfg_idx,
    input  logic [CfgW-1:0]           i_cfg_data
);

    logic [ThrW-1:0] r_threshold;
    logic [LimW-1:0] r_sil_limit;
    logic [LimW-1:0] r_utt_limit;

    logic            beat_valid, beat_ready;
    t_frame_beat     beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= ThrReset;
            r_sil_limit <= SilReset;
            r_utt_limit <= UttReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_THRESHOLD: r_threshold <= i_cfg_data[ThrW-1:0];
                CFG_SIL_LIMIT: r_sil_limit <= i_cfg_data[LimW-1:0];
                CFG_UTT_LIMIT: r_utt_limit <= i_cfg_data[LimW-1:0];
                default: ;
            endcase
        end
    end

    eug_frame_acc u_frame_acc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_cmd        (i_cmd),
        .i_sample     (i_sample),
        .i_frame_last (i_frame_last),
        .o_beat_valid (beat_valid),
        .i_beat_ready (beat_ready),
        .o_beat       (beat)
    );

    eug_gate u_gate (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_beat_valid (beat_valid),
        .o_beat_ready (beat_ready),
        .i_beat       (beat),
        .i_threshold  (r_threshold),
        .i_sil_limit  (r_sil_limit),
        .i_utt_limit  (r_utt_limit),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_keep       (o_keep),
        .o_complete   (o_complete),
        .o_started    (o_started)
    );

endmodule
